// ===== sv/i8dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8dq_pkg
// Shared types and constants of the int8 to fp16 dequantizer.
// ----------------------------------------------------------------------------
package i8dq_pkg;
	localparam logic [7:0] ExpAllOnes = 8'hFF;
	localparam logic [15:0] HalfInf = 16'h7C00;
	localparam logic [15:0] HalfNegInf = 16'hFC00;

	// Register indexes on the configuration port.
	localparam logic [0:0] RegScale = 1'b0;
	localparam logic [0:0] RegZero = 1'b1;

	// Stage 1 to stage 2 payload.
	typedef struct packed {
		logic        sign;
		logic        special;
		logic [15:0] special_val;
		logic        zero;
		logic [8:0]  exp;
		logic [31:0] prod;
		logic        last;
	} mul_t;
endpackage
`default_nettype wire

// ===== sv/i8dq_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8dq_mul
// Stage 1: difference magnitude times scale significand, special cases.
// ----------------------------------------------------------------------------
module i8dq_mul import i8dq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vin,
	input  wire logic [7:0]  sample,
	input  wire logic        last_in,
	input  wire logic [31:0] scale_bits,
	input  wire logic [7:0]  zero_offset,
	output logic             v_s1,
	output mul_t             d_s1
);
	logic signed [8:0] diff;
	logic [7:0] mag;
	logic [23:0] sig;
	logic dsign;
	mul_t nx;

	always_comb begin
		diff = $signed({sample[7], sample}) - $signed({zero_offset[7], zero_offset});
		dsign = diff[8];
		mag = dsign ? 8'(-diff) : diff[7:0];
		// Subnormal scales use an implicit zero and exponent one.
		sig = {(scale_bits[30:23] != 8'd0), scale_bits[22:0]};
		nx.sign = scale_bits[31] ^ dsign;
		nx.exp = (scale_bits[30:23] == 8'd0) ? 9'd1 : {1'b0, scale_bits[30:23]};
		nx.prod = 32'(sig * mag);
		nx.zero = (mag == 8'd0) || (sig == 24'd0);
		nx.last = last_in;
		nx.special = (scale_bits[30:23] == ExpAllOnes);
		if (scale_bits[22:0] != 23'd0)
			nx.special_val = {scale_bits[31], HalfInf[14:0]};
		else if (mag == 8'd0)
			nx.special_val = HalfNegInf;
		else
			nx.special_val = {nx.sign, HalfInf[14:0]};
		// A zero difference keeps the sign of the scale.
		if (mag == 8'd0) nx.sign = scale_bits[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) d_s1 <= nx;
	end
endmodule
`default_nettype wire

// ===== sv/i8dq_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i8dq_norm
// Stages 2 and 3: leading-one search, fp32 rounding, fp16 truncation.
// ----------------------------------------------------------------------------
module i8dq_norm import i8dq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        v_s1,
	input  wire mul_t        d_s1,
	output logic             v_s3,
	output logic [15:0]      half_s3,
	output logic             last_s3
);
	// Product value = prod * 2^(exp-127-23); leading one at bit lz.
	logic [4:0] lz;
	logic [31:0] nrm;
	logic signed [10:0] e32;
	logic v_s2, sign_s2, zero_s2, spec_s2, last_s2;
	logic [15:0] sv_s2;
	logic [31:0] nrm_s2;
	logic signed [10:0] e_s2;

	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 32; i++)
			if (d_s1.prod[i]) lz = 5'(i);
		nrm = d_s1.prod << (5'd31 - lz);
		// Unbiased: exp-127 + lz-23; biased fp32 = exp + lz - 23.
		e32 = $signed({2'b0, d_s1.exp}) + $signed({6'b0, lz}) - 11'sd23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2 <= d_s1.sign;
			zero_s2 <= d_s1.zero;
			spec_s2 <= d_s1.special;
			sv_s2 <= d_s1.special_val;
			last_s2 <= d_s1.last;
			nrm_s2 <= nrm;
			e_s2 <= e32;
		end
	end

	// Stage 3 logic. Results below fp32 normal range flush anyway (fp16 e<=0),
	// so only normal fp32 rounding matters; rounding can bump the exponent.
	logic [24:0] rnd;
	logic g, st, up;
	logic signed [11:0] eh;
	logic [15:0] h;
	always_comb begin
		g = nrm_s2[7];
		st = |nrm_s2[6:0];
		up = g && (st || nrm_s2[8]);
		rnd = {1'b0, nrm_s2[31:8]} + {24'd0, up};
		eh = rnd[24] ? 12'(e_s2) + 12'sd1 - 12'sd112 : 12'(e_s2) - 12'sd112;
		if (spec_s2) h = sv_s2;
		else if (zero_s2 || eh <= 12'sd0) h = {sign_s2, 15'd0};
		else if (eh >= 12'sd31) h = {sign_s2, HalfInf[14:0]};
		else h = {sign_s2, eh[4:0], rnd[24] ? rnd[23:14] : rnd[22:13]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s3 <= h;
			last_s3 <= last_s2;
		end
	end
endmodule
`default_nettype wire

// ===== sv/int8_dequant_to_fp16.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int8_dequant_to_fp16
// Streaming int8 to fp16 dequantizer with an APB register port.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed int8 sample. The block subtracts
// the zero point, multiplies by the fp32 scale with round-to-nearest-even,
// and truncates the product to fp16 (flush to signed zero on underflow,
// signed infinity on overflow). One transaction is accepted per cycle while
// the output is not stalled; the pipeline has a multiply stage, a normalize
// stage and a round-and-pack stage. The whole pipeline advances together and
// holds when the output is stalled, so the input ready follows the output
// ready combinationally. Registers: scale_bits at 0x0, zero_offset at 0x4;
// write them only while the pipeline is empty.
module int8_dequant_to_fp16 import i8dq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] sample
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [15:0] half_bits
	output logic             m_tlast
);
	logic [31:0] scale_q;
	logic [7:0] zero_q;
	logic en, v_s1;
	mul_t d_s1;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'h3F80_0000;
			zero_q <= 8'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == RegScale) scale_q <= pwdata;
			else zero_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == RegZero) ? {24'd0, zero_q} : scale_q;

	// The pipeline moves whenever the output slot is empty or being taken.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	i8dq_mul u_mul (
		.clk, .arst_n, .en,
		.vin(s_tvalid),
		.sample(s_tdata),
		.last_in(s_tlast),
		.scale_bits(scale_q),
		.zero_offset(zero_q),
		.v_s1, .d_s1
	);

	i8dq_norm u_norm (
		.clk, .arst_n, .en, .v_s1, .d_s1,
		.v_s3(m_tvalid),
		.half_s3(m_tdata),
		.last_s3(m_tlast)
	);
endmodule
`default_nettype wire
